>>> hdl/md5_pkg.sv
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef logic [31:0] word_t;

  // controller to datapath
  typedef struct packed {
    logic       init;       // load initial chaining words and clear count
    logic       emit;       // copy the chaining words into the digest register
    logic       wr_byte;    // write wr_data at the fill position, advance count
    logic       wr_pad;     // write padding byte at pad_idx
    logic [5:0] pad_idx;
    logic [1:0] pad_kind;   // 0: 0x80, 1: zero, 2: length byte
    logic       round_start;
    logic       round_step;
    logic       round_fold;
    logic       latch_len;
  } md5_cmd_t;

  localparam logic [1:0] PAD_MARK = 2'd0;
  localparam logic [1:0] PAD_ZERO = 2'd1;
  localparam logic [1:0] PAD_LEN  = 2'd2;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
  } md5_stat_t;

  function automatic word_t round_const(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] r;
    case (sel)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word index for round i
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'((5 * i[3:0]) + 1);
      2'd2: g = 4'((3 * i[3:0]) + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

>>> hdl/md5_datapath.sv
module md5_datapath
  import md5_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  md5_cmd_t   cmd,
  input  logic [7:0] wr_data,
  output md5_stat_t  stat,
  output logic [63:0] digest_low,
  output logic [63:0] digest_high
);

  // 16 message words as a memory: one write port (byte lanes), one read port
  logic [7:0] buf0 [0:15];
  logic [7:0] buf1 [0:15];
  logic [7:0] buf2 [0:15];
  logic [7:0] buf3 [0:15];
  word_t      msg_word;

  logic [63:0] bit_count;
  logic [63:0] len_hold;
  word_t h0, h1, h2, h3;
  word_t a, b, c, d;
  logic [5:0] round;
  logic       busy;

  logic [5:0] wr_idx;
  logic [7:0] wr_val;
  logic       wr_en;
  logic [5:0] rd_round;

  always_comb begin
    wr_en  = cmd.wr_byte | cmd.wr_pad;
    wr_idx = cmd.wr_byte ? bit_count[8:3] : cmd.pad_idx;
    case (cmd.pad_kind)
      PAD_MARK: wr_val = PAD_BYTE;
      PAD_LEN:  wr_val = len_hold[{cmd.pad_idx[2:0], 3'b000} +: 8];
      default:  wr_val = 8'h00;
    endcase
    if (cmd.wr_byte) wr_val = wr_data;
  end

  // read the word for the next round into a register ahead of its use
  assign rd_round = cmd.round_start ? 6'd0 : 6'(round + 6'd1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_idx[1:0])
        2'd0: buf0[wr_idx[5:2]] <= wr_val;
        2'd1: buf1[wr_idx[5:2]] <= wr_val;
        2'd2: buf2[wr_idx[5:2]] <= wr_val;
        default: buf3[wr_idx[5:2]] <= wr_val;
      endcase
    end
    msg_word <= {buf3[word_sel(rd_round)], buf2[word_sel(rd_round)],
                 buf1[word_sel(rd_round)], buf0[word_sel(rd_round)]};
  end

  word_t f_val;
  word_t sum;
  word_t rot;
  logic [4:0] sh;

  always_comb begin
    case (round[5:4])
      2'd0: f_val = (b & c) | (~b & d);
      2'd1: f_val = (b & d) | (c & ~d);
      2'd2: f_val = b ^ c ^ d;
      default: f_val = c ^ (b | ~d);
    endcase
    sum = a + f_val + round_const(round) + msg_word;
    sh  = rot_amount({round[5:4], round[1:0]});
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      h0 <= INIT_A;
      h1 <= INIT_B;
      h2 <= INIT_C;
      h3 <= INIT_D;
      bit_count <= '0;
    end else begin
      if (cmd.wr_byte) bit_count <= bit_count + 64'd8;
      if (cmd.round_fold) begin
        h0 <= h0 + a;
        h1 <= h1 + b;
        h2 <= h2 + c;
        h3 <= h3 + d;
      end
    end
    if (cmd.latch_len) len_hold <= bit_count;
    if (cmd.round_start) begin
      a <= h0; b <= h1; c <= h2; d <= h3;
      round <= '0;
    end else if (cmd.round_step) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rot;
      round <= 6'(round + 6'd1);
    end
  end

  // hold the finished digest while the chaining words restart
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest_low  <= {h1, h0};
      digest_high <= {h3, h2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else if (cmd.round_start) busy <= 1'b1;
    else if (cmd.round_fold) busy <= 1'b0;
  end

  assign stat.fill  = bit_count[8:3];
  assign stat.round = round;

  assert property (@(posedge clk) disable iff (rst) cmd.round_step |-> busy)
    else $error("round step outside a compression");
  assert property (@(posedge clk) disable iff (rst) cmd.wr_byte |=> $past(bit_count) + 64'd8
                   == bit_count)
    else $error("bit count did not advance by one byte");
  assert property (@(posedge clk) disable iff (rst) busy |-> !wr_en)
    else $error("buffer written during compression");

endmodule

>>> hdl/md5_control.sv
module md5_control
  import md5_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       byte_present,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  input  md5_stat_t  stat,
  output md5_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_COMP  = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic [5:0] pad_pos, pad_pos_next;
  logic       closing, closing_next;  // padding still to be done after block
  logic       marked, marked_next;    // 0x80 already written
  logic       final_blk, final_blk_next;
  logic       out_full;               // digest register holds an untaken item

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;

  always_comb begin
    state_next     = state;
    pad_pos_next   = pad_pos;
    closing_next   = closing;
    marked_next    = marked;
    final_blk_next = final_blk;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr_byte  = byte_present;
          closing_next = end_of_message;
          marked_next  = 1'b0;
          final_blk_next = 1'b0;
          if (byte_present && stat.fill == 6'd63) begin
            state_next = S_START;
          end else if (end_of_message) begin
            state_next = S_PAD;
            pad_pos_next = byte_present ? 6'(stat.fill + 6'd1) : stat.fill;
          end
        end
      end
      S_PAD: begin
        cmd.wr_pad  = 1'b1;
        cmd.pad_idx = pad_pos;
        cmd.latch_len = 1'b1;
        if (!marked) begin
          cmd.pad_kind = PAD_MARK;
          marked_next = 1'b1;
          final_blk_next = (pad_pos < LEN_POS);
        end else if (final_blk && pad_pos >= LEN_POS) begin
          cmd.pad_kind = PAD_LEN;
        end else begin
          cmd.pad_kind = PAD_ZERO;
        end
        pad_pos_next = 6'(pad_pos + 6'd1);
        if (pad_pos == 6'd63) begin
          state_next = S_START;
          if (!marked) closing_next = (pad_pos >= LEN_POS);
          else closing_next = !final_blk;
        end
      end
      S_START: begin
        cmd.round_start = 1'b1;
        state_next = S_COMP;
      end
      S_COMP: begin
        cmd.round_step = 1'b1;
        if (stat.round == 6'd63) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.round_fold = 1'b1;
        if (closing) begin
          state_next = S_PAD;
          pad_pos_next = '0;
          final_blk_next = marked;
        end else if (marked) begin
          state_next = S_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        // wait only while the previous digest is still untaken
        if (!out_full || out_ready) begin
          cmd.emit = 1'b1;
          cmd.init = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pad_pos   <= '0;
      closing   <= 1'b0;
      marked    <= 1'b0;
      final_blk <= 1'b0;
      out_full  <= 1'b0;
    end else begin
      state     <= state_next;
      pad_pos   <= pad_pos_next;
      closing   <= closing_next;
      marked    <= marked_next;
      final_blk <= final_blk_next;
      if (cmd.emit) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (state == S_COMP && stat.round == 6'd63) |=> state == S_FOLD)
    else $error("compression did not end after 64 rounds");
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_OUT) |-> marked)
    else $error("digest shown before padding");
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_ready) |=> out_valid)
    else $error("digest dropped while waiting");

endmodule

>>> hdl/md5_message_digest.sv
// MD5 digest engine. One message byte per input item (tdata[7:0]); tuser[0]
// marks the byte as present and tlast closes the message. Bytes are taken one
// per cycle until a 64-byte block is full; the block then runs 64 rounds of
// compression, one per clock, through start, rounds and fold, in which no
// item is taken. Closing a message writes the padding one byte per cycle up
// to the block end, runs one or two further compressions and, in the state
// after the last fold, once the previous digest is taken, moves the 128-bit
// digest (bytes 0..15 from the low bit up) into an output register that
// holds it until taken. The engine is then ready for the next message; it
// stalls at the next message end only while the previous digest is still waiting.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // byte_present
  input  logic         s_axis_tlast,   // end_of_message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_low, digest_high
);

  md5_cmd_t  cmd;
  md5_stat_t stat;
  logic [63:0] digest_low, digest_high;

  md5_control u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .byte_present(s_axis_tuser),
    .end_of_message(s_axis_tlast),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .stat, .cmd
  );

  md5_datapath u_dp (
    .clk, .rst, .cmd,
    .wr_data(s_axis_tdata),
    .stat,
    .digest_low, .digest_high
  );

  assign m_axis_tdata = {digest_high, digest_low};

  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("digest changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("digest withdrawn before it was taken");
  assert property (@(posedge clk) disable iff (rst)
                   (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken right after a message end");

endmodule
